// File: hw/rtl/r2h_pkg.sv
package r2h_pkg;

  // Pixel request and result payloads
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] hue_out;
    logic [7:0] sat_out;
    logic [7:0] val_out;
  } hsv_out_t;

  // Sextant bases; every hue sum stays below 2048
  localparam int unsigned SUM_W = 11;
  localparam logic [SUM_W-1:0] BASE_LOW  = SUM_W'(1 * 256);
  localparam logic [SUM_W-1:0] BASE_MID  = SUM_W'(3 * 256);
  localparam logic [SUM_W-1:0] BASE_HIGH = SUM_W'(5 * 256);

  // One quotient bit per divider stage
  localparam int unsigned DIV_STEPS = 8;

  // Divide by 6 as multiply by ceil(2^14 / 6) and shift; exact below 8192
  localparam int unsigned RECIP_SHIFT = 14;
  localparam int unsigned RECIP_W     = 12;
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6);
  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  // One lane of the restoring divider: dividend byte shifts out of lo,
  // quotient bits shift into q
  typedef struct packed {
    logic [7:0] div;
    logic [7:0] rem;
    logic [7:0] lo;
    logic [7:0] q;
  } div_lane_t;

  // Hue control that rides along with the divider
  typedef struct packed {
    logic [SUM_W-1:0] base;
    logic             add;
    logic             grey;
  } hue_side_t;

  // One restoring division step; remainder stays below the divisor
  function automatic div_lane_t div_step(input div_lane_t cur);
    div_lane_t  res;
    logic [8:0] trial;
    logic [8:0] diff;
    logic       fits;
    trial = {cur.rem, cur.lo[7]};
    diff  = trial - {1'b0, cur.div};
    fits  = (trial >= {1'b0, cur.div});
    res.div = cur.div;
    res.rem = fits ? diff[7:0] : trial[7:0];
    res.lo  = {cur.lo[6:0], 1'b0};
    res.q   = {cur.q[6:0], fits};
    return res;
  endfunction

  // Seed a lane from a 16-bit dividend whose quotient fits in 8 bits
  function automatic div_lane_t div_seed(input logic [15:0] num, input logic [7:0] div);
    div_lane_t res;
    res.div = div;
    res.rem = num[15:8];
    res.lo  = num[7:0];
    res.q   = 8'd0;
    return res;
  endfunction

endpackage

// File: hw/rtl/rgb_to_hsv_8bit_core.sv
// RGB to HSV converter, 8 bits per channel.
// Request channel: drive in_data with one pixel and raise start; the pixel is
// taken at every clock edge where start is high and busy is low. busy stays
// low, so a new pixel may be offered on every cycle.
// Result channel: out_valid pulses for one cycle with hue, saturation and
// value on out_data. Results come back in request order, one per pixel.
// Each pixel passes stages A and B, the divider stages, stages C and D and the output register.
// Throughput: one pixel per clock. The two divisions (saturation and the hue
// term) each run through an 8-stage restoring divider, one quotient bit per
// stage; the divide by 6 is a registered multiply by a reciprocal.
// Reset (rst_n low, synchronous) clears every valid bit in the pipe; pixels
// in flight are dropped and no result is shown until new requests arrive.
// The receiver cannot stall: each result is shown once and then replaced.
module rgb_to_hsv_8bit_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  r2h_pkg::pix_in_t  in_data,
  output logic              out_valid,
  output r2h_pkg::hsv_out_t out_data
);

  localparam int unsigned SW = r2h_pkg::SUM_W;
  localparam int unsigned NS = r2h_pkg::DIV_STEPS;

  // Stage A: extremes and sextant choice
  logic [7:0]    r, g, b;
  logic [7:0]    mx_rg, mn_rg, vmax, vmin, chan;
  logic          max_r, max_g;
  logic [SW-1:0] base;
  logic          add;
  logic          a_vld_r;
  logic [7:0]    a_vmax_r, a_vmin_r, a_chan_r;
  logic [SW-1:0] a_base_r;
  logic          a_add_r;

  // Stage B: spread and dividends
  logic [7:0]           spread, chan_dist;
  logic                 b_vld_r;
  r2h_pkg::div_lane_t   b_sat_r, b_hue_r;
  r2h_pkg::hue_side_t   b_side_r;

  // Divider stages
  r2h_pkg::div_lane_t   sat_lane_r [NS];
  r2h_pkg::div_lane_t   hue_lane_r [NS];
  r2h_pkg::div_lane_t   sat_lane_nxt [NS];
  r2h_pkg::div_lane_t   hue_lane_nxt [NS];
  r2h_pkg::hue_side_t   side_r [NS];
  logic                 step_vld_r [NS];

  // Stage C: sextant sum
  logic                 c_vld_r;
  logic [SW-1:0]        c_sum_r;
  logic [7:0]           c_sat_r, c_val_r;
  logic                 c_grey_r;

  // Stage D: reciprocal product
  logic                        d_vld_r;
  logic [r2h_pkg::PROD_W-1:0]  d_prod_r;
  logic [7:0]                  d_sat_r, d_val_r;
  logic                        d_grey_r;

  // Stage E: output register
  logic              out_valid_r;
  r2h_pkg::hsv_out_t out_data_r;

  logic [SW-1:0] last_q;
  logic [SW-1:0] sum_nxt;

  // Never hold off requests
  assign busy = 1'b0;

  // Find max and min with red winning ties over green, green over blue
  assign r     = in_data.red_in;
  assign g     = in_data.green_in;
  assign b     = in_data.blue_in;
  assign max_r = (r >= g) && (r >= b);
  assign max_g = !max_r && (g >= b);
  assign mx_rg = (r >= g) ? r : g;
  assign vmax  = (b > mx_rg) ? b : mx_rg;
  assign mn_rg = (r <= g) ? r : g;
  assign vmin  = (b < mn_rg) ? b : mn_rg;

  // Pick sextant base, sign and the channel whose distance gets scaled
  always_comb begin
    if (max_r) begin
      if (g == vmin) begin
        base = r2h_pkg::BASE_HIGH; add = 1'b1; chan = b;
      end else begin
        base = r2h_pkg::BASE_LOW;  add = 1'b0; chan = g;
      end
    end else if (max_g) begin
      if (b == vmin) begin
        base = r2h_pkg::BASE_LOW;  add = 1'b1; chan = r;
      end else begin
        base = r2h_pkg::BASE_MID;  add = 1'b0; chan = b;
      end
    end else begin
      if (r == vmin) begin
        base = r2h_pkg::BASE_MID;  add = 1'b1; chan = g;
      end else begin
        base = r2h_pkg::BASE_HIGH; add = 1'b0; chan = r;
      end
    end
  end

  // Spread and distance of the chosen channel from the maximum
  assign spread    = a_vmax_r - a_vmin_r;
  assign chan_dist = a_vmax_r - a_chan_r;

  // One quotient bit per stage on both lanes
  for (genvar k = 0; k < NS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign sat_lane_nxt[k] = r2h_pkg::div_step(b_sat_r);
      assign hue_lane_nxt[k] = r2h_pkg::div_step(b_hue_r);
    end else begin : g_rest
      assign sat_lane_nxt[k] = r2h_pkg::div_step(sat_lane_r[k-1]);
      assign hue_lane_nxt[k] = r2h_pkg::div_step(hue_lane_r[k-1]);
    end
  end

  // Add or subtract the scaled term from the base
  assign last_q  = {{(SW-8){1'b0}}, hue_lane_r[NS-1].q};
  assign sum_nxt = side_r[NS-1].add ? (side_r[NS-1].base + last_q)
                                    : (side_r[NS-1].base - last_q);

  // Advance valid bits; reset drops everything in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        step_vld_r[i] <= 1'b0;
      end
    end else begin
      a_vld_r <= start && !busy;
      b_vld_r <= a_vld_r;
      step_vld_r[0] <= b_vld_r;
      for (int i = 1; i < NS; i++) begin
        step_vld_r[i] <= step_vld_r[i-1];
      end
      c_vld_r     <= step_vld_r[NS-1];
      d_vld_r     <= c_vld_r;
      out_valid_r <= d_vld_r;
    end
  end

  // Advance payload through every stage
  always_ff @(posedge clk) begin
    a_vmax_r <= vmax;
    a_vmin_r <= vmin;
    a_chan_r <= chan;
    a_base_r <= base;
    a_add_r  <= add;

    // spread*255 over vmax, distance*255 over spread
    b_sat_r       <= r2h_pkg::div_seed({spread, 8'd0} - {8'd0, spread}, a_vmax_r);
    b_hue_r       <= r2h_pkg::div_seed({chan_dist, 8'd0} - {8'd0, chan_dist}, spread);
    b_side_r.base <= a_base_r;
    b_side_r.add  <= a_add_r;
    b_side_r.grey <= (spread == 8'd0);

    sat_lane_r[0] <= sat_lane_nxt[0];
    hue_lane_r[0] <= hue_lane_nxt[0];
    side_r[0]     <= b_side_r;
    for (int i = 1; i < NS; i++) begin
      sat_lane_r[i] <= sat_lane_nxt[i];
      hue_lane_r[i] <= hue_lane_nxt[i];
      side_r[i]     <= side_r[i-1];
    end

    c_sum_r  <= sum_nxt;
    c_sat_r  <= sat_lane_r[NS-1].q;
    c_val_r  <= sat_lane_r[NS-1].div;
    c_grey_r <= side_r[NS-1].grey;

    d_prod_r <= {{r2h_pkg::RECIP_W{1'b0}}, c_sum_r} *
                {{SW{1'b0}}, r2h_pkg::RECIP_6};
    d_sat_r  <= c_sat_r;
    d_val_r  <= c_val_r;
    d_grey_r <= c_grey_r;

    // Grey and black pixels give zero hue and saturation
    out_data_r.hue_out <= d_grey_r ? 8'd0 : d_prod_r[r2h_pkg::RECIP_SHIFT +: 8];
    out_data_r.sat_out <= d_grey_r ? 8'd0 : d_sat_r;
    out_data_r.val_out <= d_val_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FULL_SCALE   = 255;
  localparam int unsigned HUE_SEXTANTS = 6;
  localparam int unsigned PIPE_LATENCY = 13;
  localparam int unsigned QUIET_LIMIT  = 400;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned REPORT_MAX   = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  r2h_pkg::pix_in_t   in_data = '0;
  logic               out_valid;
  r2h_pkg::hsv_out_t  out_data;

  r2h_pkg::hsv_out_t expected_hsv_q [$];
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;

  rgb_to_hsv_8bit_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predict hue, saturation and value of one pixel
  function automatic r2h_pkg::hsv_out_t hsv_predict(input r2h_pkg::pix_in_t px);
    int unsigned r, g, b, vmax, vmin, spread, sat, hue, sum;
    int unsigned r_term, g_term, b_term;
    r2h_pkg::hsv_out_t res;
    r = 32'(px.red_in);
    g = 32'(px.green_in);
    b = 32'(px.blue_in);
    vmax = (r > g) ? r : g;
    if (b > vmax) vmax = b;
    vmin = (r < g) ? r : g;
    if (b < vmin) vmin = b;
    spread = vmax - vmin;
    sat = (vmax != 0) ? (spread * FULL_SCALE) / vmax : 0;
    hue = 0;
    if (sat != 0) begin
      r_term = ((vmax - r) * FULL_SCALE) / spread;
      g_term = ((vmax - g) * FULL_SCALE) / spread;
      b_term = ((vmax - b) * FULL_SCALE) / spread;
      // Red beats green beats blue on ties for the maximum
      if (vmax == r) begin
        sum = (vmin == g) ? int'(r2h_pkg::BASE_HIGH) + b_term
                          : int'(r2h_pkg::BASE_LOW) - g_term;
      end else if (vmax == g) begin
        sum = (vmin == b) ? int'(r2h_pkg::BASE_LOW) + r_term
                          : int'(r2h_pkg::BASE_MID) - b_term;
      end else begin
        sum = (vmin == r) ? int'(r2h_pkg::BASE_MID) + g_term
                          : int'(r2h_pkg::BASE_HIGH) - r_term;
      end
      hue = sum / HUE_SEXTANTS;
    end
    res.hue_out = hue[7:0];
    res.sat_out = sat[7:0];
    res.val_out = vmax[7:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      if (err_count < REPORT_MAX) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
      err_count++;
    end
  endtask

  // Check results, record accepted requests, and watch for a hang
  always @(posedge clk) begin
    r2h_pkg::hsv_out_t exp_hsv;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_hsv_q.size() == 0) begin
          if (err_count < REPORT_MAX) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          end
          err_count++;
        end else begin
          exp_hsv = expected_hsv_q.pop_front();
          check_field("hue", exp_hsv.hue_out, out_data.hue_out);
          check_field("sat", exp_hsv.sat_out, out_data.sat_out);
          check_field("val", exp_hsv.val_out, out_data.val_out);
        end
      end
      if (start && busy === 1'b0) begin
        expected_hsv_q.push_back(hsv_predict(in_data));
      end
    end
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[rgb_to_hsv_8bit_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pixel request, with bursts and random gaps between them
  task automatic send_pixel(input r2h_pkg::pix_in_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 32);
      if (gap != 0) begin
        start   <= 1'b0;
        in_data <= r2h_pkg::pix_in_t'(24'($urandom));
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  function automatic r2h_pkg::pix_in_t random_pixel();
    r2h_pkg::pix_in_t px;
    logic [7:0]       lvl;
    px  = r2h_pkg::pix_in_t'(24'($urandom));
    lvl = 8'($urandom);
    case ($urandom_range(0, 9))
      0: px = {lvl, lvl, lvl};
      1: begin
        // Near grey: tiny spreads stress the divider
        px.red_in   = lvl;
        px.green_in = lvl ^ 8'($urandom_range(0, 3));
        px.blue_in  = lvl ^ 8'($urandom_range(0, 3));
      end
      2: px.green_in = px.red_in;
      3: px.blue_in  = px.green_in;
      4: px.blue_in  = px.red_in;
      5: begin
        px.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic test_grey_and_black();
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h808080);
    send_pixel(24'h010101);
    send_pixel(24'h010000);
    send_pixel(24'h000001);
    send_pixel(24'hFFFEFE);
  endtask

  // Primaries and pixels that cover every sextant branch
  task automatic test_sextants();
    send_pixel(24'hFF0000);
    send_pixel(24'h00FF00);
    send_pixel(24'h0000FF);
    send_pixel(24'hFF8000);
    send_pixel(24'hFF0080);
    send_pixel(24'h80FF00);
    send_pixel(24'h00FF80);
    send_pixel(24'h0080FF);
    send_pixel(24'h8000FF);
    send_pixel(24'hAA552A);
    send_pixel(24'h55AAD5);
  endtask

  // Ties for the maximum
  task automatic test_ties();
    send_pixel(24'hFFFF00);
    send_pixel(24'h00FFFF);
    send_pixel(24'hFF00FF);
    send_pixel(24'hC8C864);
    send_pixel(24'h64C8C8);
    send_pixel(24'hC864C8);
  endtask

  task automatic test_random_pixels();
    repeat (RANDOM_ITEMS) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_grey_and_black();
    test_sextants();
    test_ties();
    test_random_pixels();
    start <= 1'b0;
    // Drain the pipe, then watch for stray results
    while (expected_hsv_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("[rgb_to_hsv_8bit_core] OK");
    end else begin
      $display("[rgb_to_hsv_8bit_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/r2h_pkg.sv
hw/rtl/rgb_to_hsv_8bit_core.sv
tb/testbench.sv
